### hw/rtl/block_matching_motion_search_defines.svh
// Assertion macros for the block matching motion search block
`ifndef BLOCK_MATCHING_MOTION_SEARCH_DEFINES_SVH
`define BLOCK_MATCHING_MOTION_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define BMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/bms_pkg.sv
// Shared types and constants for the motion search block
package bms_pkg;
  localparam int unsigned BLK = 8;
  localparam int unsigned MAX_RANGE = 16;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_WORD  = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RANGE  = 3'd0,
    REG_LWIDTH = 3'd1,
    REG_LHEIGHT = 3'd2,
    REG_CWIDTH = 3'd3,
    REG_CHEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWRD,
    ST_SCAN,
    ST_DRAIN,
    ST_MERGE,
    ST_DONE
  } state_t;

  // lane control from sequencer
  typedef struct packed {
    logic       clear;
    logic       acc;
  } lane_ctl_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction
endpackage

### hw/rtl/bms_ram.sv
// Generic single-port-write RAM with registered read
module bms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/bms_lane.sv
// One SAD lane: accumulates one candidate column offset, row by row
module bms_lane import bms_pkg::*; (
  input  logic         clk,
  input  lane_ctl_t    ctl,
  input  logic [63:0]  cur_row,
  input  logic [127:0] ref_row,
  input  logic [3:0]   shift,
  output logic [13:0]  sad
);
  logic [13:0] sad_r, sad_nxt;
  logic [10:0] rowsum;
  logic [7:0]  a, b;
  always_comb begin
    rowsum = '0;
    for (int c = 0; c < 8; c++) begin
      a = cur_row[c*8 +: 8];
      b = ref_row[(int'(shift) + c)*8 +: 8];
      rowsum = rowsum + 11'(absdiff(a, b));
    end
    sad_nxt = ctl.clear ? 14'(rowsum) : sad_r + 14'(rowsum);
  end
  always_ff @(posedge clk) begin
    if (ctl.acc) sad_r <= sad_nxt;
  end
  assign sad = sad_r;
endmodule

### hw/rtl/block_matching_motion_search.sv
// Motion search top: loaders, scan sequencer, eight SAD lanes and min merge
// Load beats are taken one per cycle, back to back, while not busy, and give no result.
// Search: groups of 8 word-aligned candidate columns, each scanned row by row then drained
// (up to 4 groups x 32 rows); the result strobes once the last group is merged, or from
// ROWRD when there is no candidate; the next beat is taken the cycle after the strobe.
// rst_n sync, active low: register defaults, position/chroma zero; stores undefined.
module block_matching_motion_search import bms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_block_col,
  input  logic [8:0]  in_block_row,
  input  logic        in_chroma,
  input  logic [5:0]  in_row_index,
  input  logic [2:0]  in_word_index,
  input  logic [63:0] in_pixels,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  output logic signed [4:0] out_mv_x,
  output logic signed [4:0] out_mv_y,
  output logic [13:0] out_min_sad,
  output logic        out_found
);
`include "block_matching_motion_search_defines.svh"
  localparam int WROWS = 2*MAX_RANGE + BLK;
  localparam int WWORDS = (2*MAX_RANGE + BLK + 7) / 8;
  localparam int RW = $clog2(MAX_RANGE + 1);

  // configuration
  logic [4:0]  range_r;
  logic [12:0] lw_r, lh_r, cw_r, ch_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= 5'd16; lw_r <= 13'd1024; lh_r <= 13'd1024;
      cw_r <= 13'd512; ch_r <= 13'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RANGE:   range_r <= cfg_data[4:0];
        REG_LWIDTH:  lw_r <= cfg_data;
        REG_LHEIGHT: lh_r <= cfg_data;
        REG_CWIDTH:  cw_r <= cfg_data;
        REG_CHEIGHT: ch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // begin latch
  logic [8:0] bcol_r, brow_r;
  logic       chroma_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcol_r <= '0; brow_r <= '0; chroma_r <= 1'b0;
    end else if (accept && in_command == CMD_BEGIN) begin
      bcol_r <= in_block_col; brow_r <= in_block_row; chroma_r <= in_chroma;
    end
  end

  // current block held in flops, rows read at the lane row index
  logic [63:0] cur_r [BLK];
  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_ROW && in_row_index < 6'(BLK))
      cur_r[in_row_index[2:0]] <= in_pixels;
  end

  // window: each row stored in WWORDS words; scan reads two adjacent words
  // from two banks (even and odd word) so a 16-pixel span arrives per cycle
  localparam int BDEPTH = WROWS * ((WWORDS + 1) / 2);
  localparam int BAW = $clog2(BDEPTH);
  localparam int HW = (WWORDS + 1) / 2;
  logic        we_e, we_o;
  logic [BAW-1:0] wa, ra_e, ra_o;
  logic [63:0] rd_e, rd_o;
  logic ld_ok;
  assign ld_ok = accept && in_command == CMD_WORD && in_row_index < 6'(WROWS)
                 && in_word_index < 3'(WWORDS);
  assign we_e = ld_ok && !in_word_index[0];
  assign we_o = ld_ok && in_word_index[0];
  assign wa = BAW'(int'(in_row_index) * HW + int'(in_word_index[2:1]));
  bms_ram #(.WIDTH(64), .DEPTH(BDEPTH)) u_even (.clk, .we(we_e), .waddr(wa),
    .wdata(in_pixels), .raddr(ra_e), .rdata(rd_e));
  bms_ram #(.WIDTH(64), .DEPTH(BDEPTH)) u_odd (.clk, .we(we_o), .waddr(wa),
    .wdata(in_pixels), .raddr(ra_o), .rdata(rd_o));

  // search bounds, computed in setup
  logic signed [14:0] left_r, top_r, right_r, bottom_r, wx0_r, wy0_r, mx_r, my_r;
  logic signed [14:0] x_r, y_r;   // candidate group origin
  logic signed [14:0] xs_r;       // first group origin of each candidate row
  logic signed [14:0] gx_r, gy_r; // origin of the group being merged
  logic [2:0] r_r;                // block row being read
  state_t st_r, st_nxt;

  logic [RW-1:0] rng;
  always_comb begin
    rng = (range_r > 5'(MAX_RANGE)) ? RW'(MAX_RANGE) : RW'(range_r);
    if (chroma_r) rng = rng >> 1;
  end

  logic [12:0] pw, ph;
  assign pw = chroma_r ? cw_r : lw_r;
  assign ph = chroma_r ? ch_r : lh_r;

  // signed views of position, range and last legal origin (may be negative)
  logic signed [14:0] mx_s, my_s, rng_s, wlim_s, hlim_s;
  assign mx_s = $signed({3'b000, bcol_r, 3'b000});
  assign my_s = $signed({3'b000, brow_r, 3'b000});
  assign rng_s = $signed(15'(rng));
  assign wlim_s = $signed({2'b00, pw}) - 15'sd8;
  assign hlim_s = $signed({2'b00, ph}) - 15'sd8;

  // groups start on a window word boundary, so every lane stays in the
  // 16-pixel span; lanes left of the clipped edge are masked in the merge
  logic signed [14:0] loff, xs;
  assign loff = left_r - wx0_r;
  assign xs = wx0_r + $signed({loff[14:3], 3'b000});

  // window column of group origin
  logic signed [14:0] wcol, wrow;
  logic [2:0] wword;
  assign wcol = x_r - wx0_r;
  assign wrow = y_r - wy0_r + 15'(r_r);
  assign wword = wcol[5:3];
  always_comb begin
    ra_e = BAW'(int'(wrow) * HW + int'((wword + 3'd1) >> 1));
    ra_o = BAW'(int'(wrow) * HW + int'(wword >> 1));
  end

  // lane pipeline: read data and lane controls are both registered, so they stay in step
  logic       acc_d_r, clr_d_r;
  logic [2:0] row_d_r;
  logic       odd_d_r;
  logic [127:0] span;
  always_comb begin
    if (odd_d_r) span = {rd_e, rd_o};
    else span = {rd_o, rd_e};
  end

  lane_ctl_t lctl;
  assign lctl.clear = clr_d_r;
  assign lctl.acc = acc_d_r;
  logic [13:0] lsad [BLK];
  for (genvar g = 0; g < BLK; g++) begin : g_lane
    bms_lane u_lane (.clk, .ctl(lctl), .cur_row(cur_r[row_d_r]), .ref_row(span),
      .shift(4'(g)), .sad(lsad[g]));
  end

  // merge: sequential min over lanes in raster order (lane order = x order).
  // The last block row lands at the edge leaving DRAIN, so the group is
  // merged the cycle after, from the origin saved in DRAIN.
  logic        mrg_r;
  logic        found_r, found_nxt;
  logic [13:0] best_r, best_nxt;
  logic signed [14:0] bx_r, by_r, bx_nxt, by_nxt;
  logic signed [14:0] xg;
  always_comb begin
    found_nxt = found_r; best_nxt = best_r; bx_nxt = bx_r; by_nxt = by_r;
    xg = '0;
    if (st_r == ST_SETUP) begin
      found_nxt = 1'b0; best_nxt = '0; bx_nxt = '0; by_nxt = '0;
    end else if (mrg_r) begin
      for (int g = 0; g < BLK; g++) begin
        xg = gx_r + 15'(g);
        if (xg >= left_r && xg < right_r && (!found_nxt || lsad[g] < best_nxt)) begin
          found_nxt = 1'b1; best_nxt = lsad[g];
          bx_nxt = xg - mx_r; by_nxt = gy_r - my_r;
        end
      end
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (accept && in_command == CMD_SEARCH) st_nxt = ST_SETUP;
      ST_SETUP: st_nxt = ST_ROWRD;
      ST_ROWRD: begin
        if (top_r >= bottom_r || left_r >= right_r) st_nxt = ST_DONE;
        else st_nxt = ST_SCAN;
      end
      ST_SCAN:  if (r_r == 3'd7) st_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (x_r + 15'sd8 < right_r) st_nxt = ST_SCAN;
        else if (y_r + 15'sd1 < bottom_r) st_nxt = ST_SCAN;
        else st_nxt = ST_MERGE;
      end
      ST_MERGE: st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; acc_d_r <= 1'b0; mrg_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      acc_d_r <= (st_r == ST_SCAN);
      mrg_r <= (st_r == ST_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    clr_d_r <= (r_r == 3'd0);
    row_d_r <= r_r;
    odd_d_r <= wword[0];
    found_r <= found_nxt; best_r <= best_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    case (st_r)
      ST_SETUP: begin
        mx_r <= mx_s; my_r <= my_s;
        wx0_r <= mx_s - rng_s;
        wy0_r <= my_s - rng_s;
        left_r <= (mx_s < rng_s) ? 15'sd0 : mx_s - rng_s;
        top_r <= (my_s < rng_s) ? 15'sd0 : my_s - rng_s;
        right_r <= (mx_s + rng_s > wlim_s) ? wlim_s : mx_s + rng_s;
        bottom_r <= (my_s + rng_s > hlim_s) ? hlim_s : my_s + rng_s;
      end
      ST_ROWRD: begin
        x_r <= xs; xs_r <= xs; y_r <= top_r; r_r <= 3'd0;
      end
      ST_SCAN: r_r <= r_r + 3'd1;
      ST_DRAIN: begin
        r_r <= 3'd0;
        gx_r <= x_r; gy_r <= y_r;
        if (x_r + 15'sd8 < right_r) x_r <= x_r + 15'sd8;
        else begin
          x_r <= xs_r; y_r <= y_r + 15'sd1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_DONE);
  assign out_found = found_r;
  assign out_mv_x = found_r ? bx_r[4:0] : 5'sd0;
  assign out_mv_y = found_r ? by_r[4:0] : 5'sd0;
  assign out_min_sad = found_r ? best_r : 14'd0;

  `BMS_ASSERT_NEXT(a_done_idle, clk, rst_n, st_r == ST_DONE, st_r == ST_IDLE)
  `BMS_ASSERT_IMPL(a_busy_valid, clk, rst_n, out_valid, busy)
  `BMS_ASSERT_NEXT(a_search_busy, clk, rst_n, accept && in_command == CMD_SEARCH, busy)
endmodule

### test/tb_block_matching_motion_search.sv
// Self-checking testbench for the 8x8 full-search SAD motion search block
`timescale 1ns / 100ps

module tb_block_matching_motion_search;
  import bms_pkg::*;

  localparam int WIN_ROW_CNT = 40;
  localparam int WIN_WORD_CNT = 5;
  localparam int ITEM_GOAL = 1550;
  localparam int PHASES = 8;

  // one search outcome
  typedef struct packed {
    logic [4:0]  mv_x;
    logic [4:0]  mv_y;
    logic [13:0] sad;
    logic        found;
  } match_t;

  // Scoreboard: keeps its own copy of the block's stores and registers,
  // predicts each search when it is accepted and checks strobed results
  // against the oldest pending one.
  class sad_scoreboard;
    bit [63:0]   cur_rows[8];
    bit [63:0]   window[WIN_ROW_CNT * WIN_WORD_CNT];
    bit [8:0]    pos_col, pos_row;
    bit          chroma_sel;
    bit [4:0]    range_reg;
    bit [12:0]   luma_w, luma_h, chroma_w, chroma_h;
    match_t      pending_matches[$];
    int          errors;

    function new();
      foreach (cur_rows[i]) cur_rows[i] = '0;
      foreach (window[i]) window[i] = '0;
      pos_col = '0; pos_row = '0; chroma_sel = 1'b0;
      range_reg = 5'd16;
      luma_w = 13'd1024; luma_h = 13'd1024;
      chroma_w = 13'd512; chroma_h = 13'd512;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
        REG_RANGE:   range_reg = data[4:0];
        REG_LWIDTH:  luma_w = data;
        REG_LHEIGHT: luma_h = data;
        REG_CWIDTH:  chroma_w = data;
        REG_CHEIGHT: chroma_h = data;
        default: ;
      endcase
    endfunction

    // exhaustive scan, first strict minimum in raster order wins
    function match_t best_match();
      match_t m;
      int rng, w, h, mx, my, lft, top, rgt, bot, wx0, wy0, bx, by, wx, wy;
      int unsigned best, sad, a, p;
      bit hit;
      rng = (range_reg > 16) ? 16 : int'(range_reg);
      w = int'(luma_w); h = int'(luma_h);
      if (chroma_sel) begin
        rng = rng / 2;
        w = int'(chroma_w); h = int'(chroma_h);
      end
      mx = int'(pos_col) * 8; my = int'(pos_row) * 8;
      lft = mx - rng; top = my - rng; rgt = mx + rng; bot = my + rng;
      wx0 = lft; wy0 = top;
      if (lft < 0) lft = 0;
      if (top < 0) top = 0;
      if (rgt > w - 8) rgt = w - 8;
      if (bot > h - 8) bot = h - 8;
      hit = 1'b0; best = 0; bx = 0; by = 0;
      for (int y = top; y < bot; y++) begin
        for (int x = lft; x < rgt; x++) begin
          sad = 0;
          for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
              a = 32'((cur_rows[r] >> (c * 8)) & 64'hFF);
              wy = y - wy0 + r;
              wx = x - wx0 + c;
              p = 32'((window[wy * WIN_WORD_CNT + wx / 8] >> ((wx % 8) * 8)) & 64'hFF);
              sad += (a > p) ? a - p : p - a;
            end
          end
          if (!hit || sad < best) begin
            hit = 1'b1; best = sad; bx = x - mx; by = y - my;
          end
        end
      end
      m.mv_x = bx[4:0]; m.mv_y = by[4:0]; m.sad = best[13:0]; m.found = hit;
      return m;
    endfunction

    function void note_item(cmd_t cmd, logic [8:0] col, logic [8:0] row, logic chroma,
                            logic [5:0] ridx, logic [2:0] widx, logic [63:0] pix);
      case (cmd)
        CMD_BEGIN: begin
          pos_col = col; pos_row = row; chroma_sel = chroma;
        end
        CMD_ROW: if (ridx < 8) cur_rows[ridx] = pix;
        CMD_WORD: begin
          if (ridx < WIN_ROW_CNT && widx < WIN_WORD_CNT)
            window[ridx * WIN_WORD_CNT + widx] = pix;
        end
        default: pending_matches.push_back(best_match());
      endcase
    endfunction

    function void check_result(match_t got);
      match_t want;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      if (got.mv_x !== want.mv_x) begin
        $display("%0t: mv_x expected %0d actual %0d", $time,
                 $signed(want.mv_x), $signed(got.mv_x));
        errors++;
      end
      if (got.mv_y !== want.mv_y) begin
        $display("%0t: mv_y expected %0d actual %0d", $time,
                 $signed(want.mv_y), $signed(got.mv_y));
        errors++;
      end
      if (got.sad !== want.sad) begin
        $display("%0t: min_sad expected %0d actual %0d", $time, want.sad, got.sad);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_BEGIN;
  logic [8:0]  in_block_col = '0;
  logic [8:0]  in_block_row = '0;
  logic        in_chroma = 1'b0;
  logic [5:0]  in_row_index = '0;
  logic [2:0]  in_word_index = '0;
  logic [63:0] in_pixels = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_RANGE;
  logic [12:0] cfg_data = '0;
  logic        out_valid;
  logic signed [4:0] out_mv_x, out_mv_y;
  logic [13:0] out_min_sad;
  logic        out_found;

  sad_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;

  always #10 clk = ~clk;

  block_matching_motion_search i_dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_block_col, .in_block_row, .in_chroma,
    .in_row_index, .in_word_index, .in_pixels,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_mv_x, .out_mv_y, .out_min_sad, .out_found
  );

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_mv_x, out_mv_y, out_min_sad, out_found});
  end

  // Drive one beat; called at a rising edge, returns at the edge that took it.
  // start is left high so a following beat goes back to back; it is dropped
  // only when a burst runs out or in drain.
  task automatic put_item(cmd_t cmd, logic [8:0] col, logic [8:0] row, logic chroma,
                          logic [5:0] ridx, logic [2:0] widx, logic [63:0] pix);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_command <= cmd;
    in_block_col <= col;
    in_block_row <= row;
    in_chroma <= chroma;
    in_row_index <= ridx;
    in_word_index <= widx;
    in_pixels <= pix;
    do @(posedge clk); while (busy);
    sb.note_item(cmd, col, row, chroma, ridx, widx, pix);
    items_sent++;
  endtask

  // same beat, with random filler in the block column, row and chroma fields
  task automatic put_cmd(cmd_t cmd, logic [5:0] ridx, logic [2:0] widx, logic [63:0] pix);
    put_item(cmd, 9'($urandom), 9'($urandom), 1'($urandom), ridx, widx, pix);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let every pending search finish, plus slack for a trailing load
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // pixel data: full random, low-contrast (makes SAD ties likely) or flat
  function automatic logic [63:0] rand_pixels();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = {$urandom, $urandom};
      2: for (int i = 0; i < 8; i++) v[i*8 +: 8] = 8'($urandom_range(0, 3));
      default: v = {8{8'($urandom)}};
    endcase
    return v;
  endfunction

  // block position, biased to the plane corners and edges
  function automatic logic [8:0] pick_pos(logic [12:0] plane);
    int p;
    case ($urandom_range(0, 5))
      0: p = 0;
      1: p = 1;
      2: p = 511;
      3: p = int'(plane) / 8 - $urandom_range(0, 2);
      default: p = $urandom_range(0, 511);
    endcase
    if (p < 0) p = 0;
    if (p > 511) p = 511;
    return 9'(p);
  endfunction

  // one well-formed block: begin, the 8 block rows, some window refreshes,
  // a bit of noise, then the search
  task automatic run_block();
    logic ch;
    int order[8];
    ch = 1'($urandom);
    put_item(CMD_BEGIN, pick_pos(ch ? sb.chroma_w : sb.luma_w),
             pick_pos(ch ? sb.chroma_h : sb.luma_h), ch,
             6'($urandom), 3'($urandom), {$urandom, $urandom});
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i]) put_cmd(CMD_ROW, 6'(order[i]), 3'($urandom), rand_pixels());
    repeat ($urandom_range(0, 12))
      put_cmd(CMD_WORD, 6'($urandom_range(0, WIN_ROW_CNT - 1)),
              3'($urandom_range(0, WIN_WORD_CNT - 1)), rand_pixels());
    // out-of-range indexes, which the block must drop
    if ($urandom_range(0, 3) == 0) begin
      put_cmd(CMD_ROW, 6'($urandom_range(8, 63)), 3'($urandom), {$urandom, $urandom});
      put_cmd(CMD_WORD, 6'($urandom_range(WIN_ROW_CNT, 63)), 3'($urandom),
              {$urandom, $urandom});
      put_cmd(CMD_WORD, 6'($urandom), 3'($urandom_range(WIN_WORD_CNT, 7)),
              {$urandom, $urandom});
    end
    // broken sequence: a stray search before the real one
    if ($urandom_range(0, 7) == 0)
      put_cmd(CMD_SEARCH, 6'($urandom), 3'($urandom), {$urandom, $urandom});
    put_cmd(CMD_SEARCH, 6'($urandom), 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic set_phase(int p);
    case (p)
      0: ; // reset defaults
      1: begin // range saturates, large planes
        write_cfg(REG_RANGE, 13'd31);
        write_cfg(REG_LWIDTH, 13'd4096);  write_cfg(REG_LHEIGHT, 13'd4096);
        write_cfg(REG_CWIDTH, 13'd4096);  write_cfg(REG_CHEIGHT, 13'd4096);
      end
      2: begin // zero range: no candidate anywhere
        write_cfg(REG_RANGE, 13'd0);
        write_cfg(REG_LWIDTH, 13'd1024);  write_cfg(REG_LHEIGHT, 13'd1024);
      end
      3: begin // planes of one block: no candidate
        write_cfg(REG_RANGE, 13'd16);
        write_cfg(REG_LWIDTH, 13'd8);     write_cfg(REG_LHEIGHT, 13'd8);
        write_cfg(REG_CWIDTH, 13'd8);     write_cfg(REG_CHEIGHT, 13'd8);
      end
      4: begin // tiny planes, range one
        write_cfg(REG_RANGE, 13'd1);
        write_cfg(REG_LWIDTH, 13'd16);    write_cfg(REG_LHEIGHT, 13'd24);
        write_cfg(REG_CWIDTH, 13'd8);     write_cfg(REG_CHEIGHT, 13'd16);
      end
      5: begin // anything goes, including unknown register indexes
        for (int i = int'(REG_CHEIGHT) + 1; i < 8; i++)
          write_cfg(3'(i), 13'($urandom));
        write_cfg(REG_RANGE, 13'($urandom));
        write_cfg(REG_LWIDTH, 13'($urandom));  write_cfg(REG_LHEIGHT, 13'($urandom));
        write_cfg(REG_CWIDTH, 13'($urandom));  write_cfg(REG_CHEIGHT, 13'($urandom));
      end
      6: begin // just above the range limit, ordinary planes
        write_cfg(REG_RANGE, 13'd17);
        write_cfg(REG_LWIDTH, 13'd1024);  write_cfg(REG_LHEIGHT, 13'd1024);
        write_cfg(REG_CWIDTH, 13'd512);   write_cfg(REG_CHEIGHT, 13'd512);
      end
      default: begin // every data bit set
        write_cfg(REG_RANGE, 13'h1FFF);
        write_cfg(REG_LWIDTH, 13'h1FFF);  write_cfg(REG_LHEIGHT, 13'h1FFF);
        write_cfg(REG_CWIDTH, 13'h1FFF);  write_cfg(REG_CHEIGHT, 13'h1FFF);
      end
    endcase
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every store entry so no search reads unwritten data.
    // Window all zero, block all 0xFF: worst-case SAD at the top-left corner.
    put_cmd(CMD_BEGIN, 6'd0, 3'd0, '0);
    for (int r = 0; r < 8; r++) put_cmd(CMD_ROW, 6'(r), 3'd0, '1);
    for (int r = 0; r < WIN_ROW_CNT; r++)
      for (int w = 0; w < WIN_WORD_CNT; w++) put_cmd(CMD_WORD, 6'(r), 3'(w), '0);
    put_item(CMD_BEGIN, 9'd0, 9'd0, 1'b0, '0, '0, '0);
    put_cmd(CMD_SEARCH, 6'd0, 3'd0, '0);
    // far corner in chroma, then an all-zero block for a zero SAD
    put_item(CMD_BEGIN, 9'd511, 9'd511, 1'b1, '1, '1, '1);
    put_cmd(CMD_SEARCH, '1, '1, '1);
    for (int r = 0; r < 8; r++) put_cmd(CMD_ROW, 6'(r), 3'd7, '0);
    put_item(CMD_BEGIN, 9'd5, 9'd3, 1'b0, '0, '0, '0);
    put_cmd(CMD_SEARCH, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_phase(p);
      while (items_sent < (p + 1) * ITEM_GOAL / PHASES) run_block();
    end
    drain();

    if (sb.errors == 0 && sb.pending_matches.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
